// File: design/circular_list_with_positional_delete_core_assert.svh
// Assertion macros for the checker file of this block.
`ifndef CIRCULAR_LIST_WITH_POSITIONAL_DELETE_CORE_ASSERT_SVH
`define CIRCULAR_LIST_WITH_POSITIONAL_DELETE_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CLPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CLPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/clpd_pkg.sv
package clpd_pkg;

    // field widths and depths
    localparam int VAL_W         = 32;
    localparam int POS_W         = 16;
    localparam int CNT_W         = 5;
    localparam int DEPTH_DEFAULT = 16;
    localparam int QUEUE_DEPTH   = 2;

    // func codes on the command channel
    localparam logic [1:0] FUNC_INS_FRONT = 2'd0;
    localparam logic [1:0] FUNC_INS_END   = 2'd1;
    localparam logic [1:0] FUNC_DELETE    = 2'd2;
    localparam logic [1:0] FUNC_READ      = 2'd3;

    // status codes on the response channel
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]              func;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } clpd_in_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [VAL_W-1:0] item_value;
        logic [CNT_W-1:0]        entry_count;
        logic                    last_of_run;
    } clpd_out_t;

    typedef enum logic [1:0] {
        OP_INS_FRONT,
        OP_INS_END,
        OP_DELETE,
        OP_READ
    } clpd_op_t;

    // classified command as queued between front and back
    typedef struct packed {
        clpd_op_t                op;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        dividend;
        logic                    use_mod;
    } clpd_cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_DEL_RD,
        S_DEL_CAP,
        S_SH_RD,
        S_SH_WR,
        S_DEL_FIN,
        S_EMIT,
        S_RD_ADDR,
        S_RD_EMIT
    } clpd_state_t;

endpackage

// File: design/clpd_front.sv
module clpd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  clpd_pkg::clpd_in_t  cmd_data,
    input  logic                q_full,
    output logic                q_push,
    output clpd_pkg::clpd_cmd_t q_cmd
);
    import clpd_pkg::*;

    logic      hold_valid_reg;
    logic      hold_valid_next;
    clpd_cmd_t cmd_reg;
    clpd_cmd_t cmd_next;
    logic      accept;

    // one holding stage in front of the queue
    assign q_push    = hold_valid_reg && !q_full;
    assign cmd_stall = hold_valid_reg && q_full;
    assign accept    = cmd_valid && !cmd_stall;
    assign q_cmd     = cmd_reg;

    // classify the incoming transaction
    always_comb
    begin
        cmd_next          = cmd_reg;
        hold_valid_next   = hold_valid_reg && !q_push;
        if (accept)
        begin
            hold_valid_next = 1'b1;
            cmd_next.value  = cmd_data.value;
            case (cmd_data.func)
                FUNC_INS_FRONT: cmd_next.op = OP_INS_FRONT;
                FUNC_INS_END:   cmd_next.op = OP_INS_END;
                FUNC_DELETE:    cmd_next.op = OP_DELETE;
                default:        cmd_next.op = OP_READ;
            endcase
            // positions 0 and 1 both mean the head
            if (cmd_data.position == '0)
                cmd_next.dividend = '0;
            else
                cmd_next.dividend = cmd_data.position - 1'b1;
            cmd_next.use_mod = (cmd_data.position > POS_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else
            hold_valid_reg <= hold_valid_next;
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

// File: design/clpd_queue.sv
module clpd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  clpd_pkg::clpd_cmd_t push_cmd,
    output logic                full,
    input  logic                pop,
    output logic                valid,
    output clpd_pkg::clpd_cmd_t pop_cmd
);
    import clpd_pkg::*;

    localparam int PW  = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    clpd_cmd_t        slots [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   fill_reg, fill_next;
    logic             do_push, do_pop;

    assign full    = (fill_reg == QCW'(QUEUE_DEPTH));
    assign valid   = (fill_reg != '0);
    assign pop_cmd = slots[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            fill_next = fill_reg + 1'b1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= push_cmd;
    end

endmodule

// File: design/clpd_mod.sv
module clpd_mod #(
    parameter int DEPTH = clpd_pkg::DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [clpd_pkg::POS_W-1:0]        dividend,
    input  logic [$clog2(DEPTH + 1)-1:0]      divisor,
    output logic                              done,
    output logic [$clog2(DEPTH + 1)-1:0]      rem
);
    import clpd_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int BW = $clog2(POS_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [BW-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [POS_W-1:0]  dvd_reg, dvd_next;
    logic [CW-1:0]     rem_reg, rem_next;
    logic [CW:0]       trial;
    logic [CW:0]       diff;

    assign done = done_reg;
    assign rem  = rem_reg;

    // one restoring step per cycle, dividend MSB first
    assign trial = {rem_reg, dvd_reg[POS_W-1]};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        bit_cnt_next = bit_cnt_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            bit_cnt_next = BW'(POS_W - 1);
            dvd_next     = dividend;
            rem_next     = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[POS_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
                rem_next = diff[CW-1:0];
            else
                rem_next = trial[CW-1:0];
            if (bit_cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
                bit_cnt_next = bit_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            bit_cnt_reg <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            done_reg    <= done_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

endmodule

// File: design/clpd_back.sv
module clpd_back #(
    parameter int DEPTH = clpd_pkg::DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  clpd_pkg::clpd_cmd_t q_cmd,
    output logic                q_pop,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output clpd_pkg::clpd_out_t rsp_data
);
    import clpd_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW:0]   DEPTH_W  = (IW + 1)'(DEPTH);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    // logical index to slot of the ring
    function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
                                              input logic [IW-1:0] k);
        logic [IW:0] s;
        s = {1'b0, base} + {1'b0, k};
        if (s >= DEPTH_W)
            s = s - DEPTH_W;
        return s[IW-1:0];
    endfunction

    clpd_state_t      state_reg, state_next;
    clpd_cmd_t        cmd_reg, cmd_next;
    logic [IW-1:0]    head_reg, head_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [IW-1:0]    idx_reg, idx_next;
    clpd_out_t        res_reg, res_next;
    logic             rsp_valid_reg, rsp_valid_next;
    clpd_out_t        rsp_data_reg, rsp_data_next;

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] rd_data_reg;
    logic [IW-1:0]    rd_addr;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    logic [VAL_W-1:0] wr_data;

    logic             mod_start, mod_done;
    logic [CW-1:0]    mod_rem;

    logic             list_full, list_empty, rsp_free, rd_last, emit_valid;
    logic [IW-1:0]    head_dec;
    logic [CW:0]      idx_p1, idx_p2;
    clpd_out_t        emit_data;

    // wrapped delete position
    clpd_mod #(
        .DEPTH (DEPTH)
    ) u_clpd_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (cmd_reg.dividend),
        .divisor  (count_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    assign list_full  = (count_reg == FULL_CNT);
    assign list_empty = (count_reg == '0);
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign head_dec   = (head_reg == '0) ? IW'(DEPTH - 1) : head_reg - 1'b1;
    assign idx_p1     = (CW + 1)'(idx_reg) + (CW + 1)'(1);
    assign idx_p2     = idx_p1 + (CW + 1)'(1);
    assign rd_last    = (idx_p1 == {1'b0, count_reg});
    assign rsp_valid  = rsp_valid_reg;
    assign rsp_data   = rsp_data_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (q_valid)
                    state_next = S_DECODE;
            S_DECODE:
                case (cmd_reg.op)
                    OP_DELETE:
                        if (list_empty)
                            state_next = S_EMIT;
                        else if (cmd_reg.use_mod)
                            state_next = S_DIV;
                        else
                            state_next = S_DEL_RD;
                    OP_READ:
                        state_next = list_empty ? S_EMIT : S_RD_ADDR;
                    default:
                        state_next = S_EMIT;
                endcase
            S_DIV:
                if (mod_done)
                    state_next = S_DEL_RD;
            S_DEL_RD:
                state_next = S_DEL_CAP;
            S_DEL_CAP:
                state_next = (idx_p1 < {1'b0, count_reg}) ? S_SH_RD : S_DEL_FIN;
            S_SH_RD:
                state_next = S_SH_WR;
            S_SH_WR:
                state_next = (idx_p2 < {1'b0, count_reg}) ? S_SH_RD : S_DEL_FIN;
            S_DEL_FIN:
                state_next = S_EMIT;
            S_EMIT:
                if (rsp_free)
                    state_next = S_IDLE;
            S_RD_ADDR:
                state_next = S_RD_EMIT;
            S_RD_EMIT:
                if (rsp_free)
                    state_next = rd_last ? S_IDLE : S_RD_ADDR;
            default:
                state_next = S_IDLE;
        endcase
    end

    // control outputs: queue pop, memory ports, divider start, emit
    always_comb
    begin
        q_pop      = (state_reg == S_IDLE) && q_valid;
        mod_start  = 1'b0;
        rd_addr    = slot_of(head_reg, idx_reg);
        wr_en      = 1'b0;
        wr_addr    = slot_of(head_reg, idx_reg);
        wr_data    = rd_data_reg;
        emit_valid = 1'b0;
        emit_data  = res_reg;
        case (state_reg)
            S_DECODE:
                case (cmd_reg.op)
                    OP_INS_FRONT:
                    begin
                        wr_en   = !list_full;
                        wr_addr = head_dec;
                        wr_data = cmd_reg.value;
                    end
                    OP_INS_END:
                    begin
                        wr_en   = !list_full;
                        wr_addr = slot_of(head_reg, count_reg[IW-1:0]);
                        wr_data = cmd_reg.value;
                    end
                    OP_DELETE:
                        mod_start = !list_empty && cmd_reg.use_mod;
                    default:
                        mod_start = 1'b0;
                endcase
            S_SH_RD:
                rd_addr = slot_of(head_reg, idx_p1[IW-1:0]);
            S_SH_WR:
                wr_en = 1'b1;
            S_EMIT:
                emit_valid = 1'b1;
            S_RD_EMIT:
            begin
                emit_valid            = 1'b1;
                emit_data.status      = STAT_OK;
                emit_data.item_value  = rd_data_reg;
                emit_data.entry_count = CNT_W'(count_reg);
                emit_data.last_of_run = rd_last;
            end
            default:
                emit_valid = 1'b0;
        endcase
    end

    // list bookkeeping and staged result
    always_comb
    begin
        cmd_next   = cmd_reg;
        head_next  = head_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        res_next   = res_reg;
        case (state_reg)
            S_IDLE:
                if (q_valid)
                    cmd_next = q_cmd;
            S_DECODE:
            begin
                idx_next             = '0;
                res_next.item_value  = '0;
                res_next.last_of_run = 1'b1;
                case (cmd_reg.op)
                    OP_INS_FRONT, OP_INS_END:
                        if (list_full)
                        begin
                            res_next.status      = STAT_FULL;
                            res_next.entry_count = CNT_W'(count_reg);
                        end
                        else
                        begin
                            res_next.status      = STAT_OK;
                            res_next.entry_count = CNT_W'(count_reg + 1'b1);
                            count_next           = count_reg + 1'b1;
                            if (cmd_reg.op == OP_INS_FRONT)
                                head_next = head_dec;
                        end
                    default:
                    begin
                        res_next.status      = STAT_EMPTY;
                        res_next.entry_count = '0;
                    end
                endcase
            end
            S_DIV:
                if (mod_done)
                    idx_next = mod_rem[IW-1:0];
            S_DEL_CAP:
                res_next.item_value = rd_data_reg;
            S_SH_WR:
                idx_next = idx_p1[IW-1:0];
            S_DEL_FIN:
            begin
                res_next.status      = STAT_OK;
                res_next.entry_count = CNT_W'(count_reg - 1'b1);
                res_next.last_of_run = 1'b1;
                count_next           = count_reg - 1'b1;
            end
            S_RD_EMIT:
                if (rsp_free && !rd_last)
                    idx_next = idx_p1[IW-1:0];
            default:
                idx_next = idx_reg;
        endcase
    end

    // response register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_data_next  = rsp_data_reg;
        if (emit_valid && rsp_free)
        begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = emit_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        res_reg      <= res_next;
        rsp_data_reg <= rsp_data_next;
    end

    // entry storage: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

endmodule

// File: design/circular_list_with_positional_delete_core.sv
// Ordered list of up to DEPTH signed 32-bit words kept as a ring in a single-port-write,
// registered-read memory. Each command transaction inserts at the front, inserts at the
// end, deletes at a 1-based position (wrapping modulo the entry count) or reads the list
// out head first. Commands pass a holding stage and a two-entry queue, so up to three can
// be taken while the back end is busy. In the back end an insert writes its entry while
// decoding; a delete first takes the wrapped-position remainder when the position is
// above 1 (a bit-serial divider, one bit of the 16-bit position per cycle), reads and
// captures the removed entry, then moves each entry that follows it one place nearer the
// head; a read-out reads each entry from memory before it is presented. Responses leave
// through an output register, one per cycle at most.
module circular_list_with_positional_delete_core #(
    parameter int DEPTH = clpd_pkg::DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  clpd_pkg::clpd_in_t  cmd_data,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output clpd_pkg::clpd_out_t rsp_data
);
    import clpd_pkg::*;

    logic      q_full, q_push, q_valid, q_pop;
    clpd_cmd_t front_cmd, back_cmd;

    // accept and classify
    clpd_front u_clpd_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (front_cmd)
    );

    // decouple front from back
    clpd_queue u_clpd_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (front_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_cmd  (back_cmd)
    );

    // execute against the list storage
    clpd_back #(
        .DEPTH (DEPTH)
    ) u_clpd_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (back_cmd),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule

// File: design/clpd_checker.sv
`include "circular_list_with_positional_delete_core_assert.svh"

module clpd_checker #(
    parameter int DEPTH = clpd_pkg::DEPTH_DEFAULT
) (
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_valid,
    input logic                cmd_stall,
    input clpd_pkg::clpd_in_t  cmd_data,
    input logic                rsp_valid,
    input logic                rsp_stall,
    input clpd_pkg::clpd_out_t rsp_data
);
    import clpd_pkg::*;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic rsp_wait;
    logic rsp_full;
    logic rsp_empty;
    logic rsp_mid;
    logic full_rsp_ok;
    logic empty_rsp_ok;

    // response classes seen on the output side
    assign rsp_wait  = rsp_valid && rsp_stall;
    assign rsp_full  = rsp_valid && (rsp_data.status == STAT_FULL);
    assign rsp_empty = rsp_valid && (rsp_data.status == STAT_EMPTY);
    assign rsp_mid   = rsp_valid && !rsp_data.last_of_run;

    // expected shape of the error responses
    assign full_rsp_ok  = (rsp_data.entry_count == FULL_CNT) && (rsp_data.item_value == '0)
                          && rsp_data.last_of_run;
    assign empty_rsp_ok = (rsp_data.entry_count == '0) && (rsp_data.item_value == '0)
                          && rsp_data.last_of_run;

    // a stalled response holds
    `CLPD_ASSERT_NEXT(a_rsp_hold, rsp_wait, rsp_valid && $stable(rsp_data), "stalled response changed")

    // a dropped insert reports a full list and no data
    `CLPD_ASSERT_NOW(a_full_shape, rsp_full, full_rsp_ok, "bad list-full response")

    // an empty-list response carries nothing and ends its run
    `CLPD_ASSERT_NOW(a_empty_shape, rsp_empty, empty_rsp_ok, "bad list-empty response")

    // only a read-out run has results that are not its last, and they are ok
    `CLPD_ASSERT_NOW(a_run_ok, rsp_mid, rsp_data.status == STAT_OK, "bad status in read-out run")

endmodule

bind circular_list_with_positional_delete_core clpd_checker #(
    .DEPTH (DEPTH)
) u_clpd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_data  (cmd_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);
